[sv/ptn_pkg.sv]
`default_nettype none

package ptn_pkg;

    localparam int VALUE_BITS = 24;
    localparam int SIGMA_BITS = 27;

    // trial divisor stays below 2^(VALUE_BITS/2) while p*p <= remainder
    localparam int P_BITS     = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS    = 2 * P_BITS;
    localparam int ACC_BITS   = VALUE_BITS + 4;
    localparam int TERM_BITS  = VALUE_BITS + 1;

    // divider retires two quotient bits per cycle
    localparam int DIV_W      = VALUE_BITS + (VALUE_BITS % 2);
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int CNT_BITS   = $clog2(DIV_STEPS + 1);

    localparam int P_FIRST    = 2;

    typedef struct packed {
        logic load;
        logic emit;
        logic emit_ok;
        logic div_start;
        logic pow_mul;
        logic term_add;
        logic acc_mul;
        logic next_p;
        logic final_mul;
    } ptn_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic in_power;
        logic p_gt_lim;
        logic sq_gt_rem;
        logic rem_gt_one;
        logic rem_gt_lim;
        logic odd_or_zero;
    } ptn_stat_t;

endpackage

`default_nettype wire

[sv/ptn_div.sv]
`default_nettype none

module ptn_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ptn_pkg::VALUE_BITS-1:0] dividend,
    input  wire logic [ptn_pkg::P_BITS-1:0]     divisor,
    output logic                              done,
    output logic [ptn_pkg::VALUE_BITS-1:0]      quotient,
    output logic                              rem_zero
);
    import ptn_pkg::*;

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DIV_W-1:0]    q_reg, q_next;
    logic [P_BITS-1:0]   r_reg, r_next;
    logic [P_BITS-1:0]   d_reg, d_next;

    logic [P_BITS:0]     sh1, sh2, diff1, diff2, d_ext;
    logic                ge1, ge2;
    logic [P_BITS-1:0]   r1, r2;

    always_comb
    begin
        d_ext = {1'b0, d_reg};
        sh1   = {r_reg, q_reg[DIV_W-1]};
        diff1 = sh1 - d_ext;
        ge1   = sh1 >= d_ext;
        r1    = ge1 ? diff1[P_BITS-1:0] : sh1[P_BITS-1:0];
        sh2   = {r1, q_reg[DIV_W-2]};
        diff2 = sh2 - d_ext;
        ge2   = sh2 >= d_ext;
        r2    = ge2 ? diff2[P_BITS-1:0] : sh2[P_BITS-1:0];

        cnt_next  = cnt_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            cnt_next = CNT_BITS'(DIV_STEPS);
            q_next   = DIV_W'(dividend);
            r_next   = '0;
            d_next   = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
            q_next    = {q_reg[DIV_W-3:0], ge1, ge2};
            r_next    = r2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg[VALUE_BITS-1:0];
    assign rem_zero = (r_reg == '0);

    a_no_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !done)
        else $error("divider finished straight after start");

endmodule

`default_nettype wire

[sv/ptn_dp.sv]
`default_nettype none

module ptn_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ptn_pkg::ptn_cmd_t              cmd,
    input  wire logic [ptn_pkg::VALUE_BITS-1:0] value,
    output ptn_pkg::ptn_stat_t                  stat,
    output logic                                is_practical,
    output logic [ptn_pkg::SIGMA_BITS-1:0]      sigma_sum
);
    import ptn_pkg::*;

    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [P_BITS-1:0]     p_reg, p_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic [TERM_BITS-1:0]  term_reg, term_next;
    logic [VALUE_BITS-1:0] pw_reg, pw_next;
    logic                  in_power_reg, in_power_next;
    logic                  is_practical_reg, is_practical_next;
    logic [SIGMA_BITS-1:0] sigma_reg, sigma_next;

    logic                         div_done, div_rem_zero;
    logic [VALUE_BITS-1:0]        div_quot;
    logic [P_BITS-1:0]            p_step;
    logic [SQ_BITS-1:0]           p_step_sq;
    logic [TERM_BITS-1:0]         mul_b;
    logic [ACC_BITS+TERM_BITS-1:0] acc_prod;
    logic [VALUE_BITS+P_BITS-1:0] pw_prod;
    logic [ACC_BITS:0]            acc_lim;
    logic [SIGMA_BITS+ACC_BITS-1:0] acc_wide;

    ptn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rem_reg),
        .divisor  (p_reg),
        .done     (div_done),
        .quotient (div_quot),
        .rem_zero (div_rem_zero)
    );

    always_comb
    begin
        // after two only odd candidates can be prime
        p_step    = p_reg + ((p_reg == P_BITS'(P_FIRST)) ? P_BITS'(1) : P_BITS'(2));
        p_step_sq = SQ_BITS'(p_step) * SQ_BITS'(p_step);
        mul_b     = cmd.final_mul ? (TERM_BITS'(rem_reg) + 1'b1) : term_reg;
        acc_prod  = (ACC_BITS+TERM_BITS)'(acc_reg) * (ACC_BITS+TERM_BITS)'(mul_b);
        pw_prod   = (VALUE_BITS+P_BITS)'(pw_reg) * (VALUE_BITS+P_BITS)'(p_reg);
        acc_lim   = {1'b0, acc_reg} + 1'b1;
        acc_wide  = {{SIGMA_BITS{1'b0}}, acc_reg};

        rem_next          = rem_reg;
        p_next            = p_reg;
        sq_next           = sq_reg;
        acc_next          = acc_reg;
        term_next         = term_reg;
        pw_next           = pw_reg;
        in_power_next     = in_power_reg;
        is_practical_next = is_practical_reg;
        sigma_next        = sigma_reg;

        if (cmd.load)
        begin
            rem_next      = value;
            p_next        = P_BITS'(P_FIRST);
            sq_next       = SQ_BITS'(P_FIRST * P_FIRST);
            acc_next      = ACC_BITS'(1);
            term_next     = TERM_BITS'(1);
            pw_next       = VALUE_BITS'(1);
            in_power_next = 1'b0;
        end
        if (cmd.pow_mul)
        begin
            rem_next      = div_quot;
            pw_next       = pw_prod[VALUE_BITS-1:0];
            in_power_next = 1'b1;
        end
        if (cmd.term_add)
            term_next = term_reg + TERM_BITS'(pw_reg);
        if (cmd.acc_mul || cmd.final_mul)
            acc_next = acc_prod[ACC_BITS-1:0];
        if (cmd.next_p)
        begin
            p_next        = p_step;
            sq_next       = p_step_sq;
            term_next     = TERM_BITS'(1);
            pw_next       = VALUE_BITS'(1);
            in_power_next = 1'b0;
        end
        if (cmd.emit)
        begin
            is_practical_next = cmd.emit_ok;
            sigma_next        = cmd.emit_ok ? acc_wide[SIGMA_BITS-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_power_reg <= 1'b0;
        else
            in_power_reg <= in_power_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg          <= rem_next;
        p_reg            <= p_next;
        sq_reg           <= sq_next;
        acc_reg          <= acc_next;
        term_reg         <= term_next;
        pw_reg           <= pw_next;
        is_practical_reg <= is_practical_next;
        sigma_reg        <= sigma_next;
    end

    always_comb
    begin
        stat.div_done    = div_done;
        stat.rem_zero    = div_rem_zero;
        stat.in_power    = in_power_reg;
        stat.p_gt_lim    = (ACC_BITS+1)'(p_reg) > acc_lim;
        stat.sq_gt_rem   = sq_reg > SQ_BITS'(rem_reg);
        stat.rem_gt_one  = rem_reg > VALUE_BITS'(1);
        stat.rem_gt_lim  = (ACC_BITS+1)'(rem_reg) > acc_lim;
        stat.odd_or_zero = rem_reg[0] || (rem_reg == '0);
    end

    assign is_practical = is_practical_reg;
    assign sigma_sum    = sigma_reg;

    a_pow_needs_zero_rem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pow_mul |-> (div_done && div_rem_zero))
        else $error("prime power taken without exact division");

endmodule

`default_nettype wire

[sv/ptn_ctrl.sv]
`default_nettype none

module ptn_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ptn_pkg::ptn_stat_t stat,
    output ptn_pkg::ptn_cmd_t       cmd,
    output logic                    busy,
    output logic                    done
);
    import ptn_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIVW  = 3'd3;
    localparam logic [2:0] S_TERM  = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.odd_or_zero)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.sq_gt_rem)
                    state_next = S_FINAL;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        // the bound is only checked on the first factor of a prime
                        if (!stat.in_power && stat.p_gt_lim)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.pow_mul = 1'b1;
                            state_next  = S_TERM;
                        end
                    end
                    else
                    begin
                        cmd.acc_mul = stat.in_power;
                        cmd.next_p  = 1'b1;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_TERM:
            begin
                cmd.term_add  = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_FINAL:
            begin
                if (!stat.rem_gt_one)
                begin
                    cmd.emit    = 1'b1;
                    cmd.emit_ok = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.rem_gt_lim)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.final_mul = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ok = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        done_next = cmd.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe right after accepting a beat");

endmodule

`default_nettype wire

[sv/practical_number_test_top.sv]
// flow: odd or zero values are rejected straight after the load; else each trial divisor
// (2 then odd candidates up to the square root of the remaining cofactor) takes one divider
// run, plus one more run per further power of a dividing prime
// throughput: one value at a time, set by the 2-bit-per-cycle trial divider
// busy drops with the result strobe, so the next value is taken in that cycle
// reset: asynchronous, active low, returns the controller to idle with no strobe
`default_nettype none

module practical_number_test_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ptn_pkg::VALUE_BITS-1:0] value,
    output logic                                done,
    output logic                                is_practical,
    output logic [ptn_pkg::SIGMA_BITS-1:0]      sigma_sum
);
    import ptn_pkg::*;

    ptn_cmd_t  cmd;
    ptn_stat_t stat;

    ptn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ptn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .stat         (stat),
        .is_practical (is_practical),
        .sigma_sum    (sigma_sum)
    );

    a_idle_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while a result beat is shown");

    a_reject_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_practical) |-> (sigma_sum == '0))
        else $error("rejected value carries a divisor sum");

endmodule

`default_nettype wire
